// ===== rtl/lookahead_rms_compressor_assert.svh =====
// Assertion macros for the lookahead RMS compressor checker.
// Included by the checker module only; depends on nothing else.
`ifndef LOOKAHEAD_RMS_COMPRESSOR_ASSERT_SVH
`define LOOKAHEAD_RMS_COMPRESSOR_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define LRC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define LRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/lrc_pkg.sv =====
// Package for the lookahead RMS compressor: sizes, register indexes, types.
// No dependencies.
`default_nettype none
package lrc_pkg;
    localparam int WINDOW_MAX_D    = 8192;
    localparam int LOOKAHEAD_MAX_D = 128;
    localparam int SAMPLE_BITS_D   = 16;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLOPE     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAKEUP    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOOKAHEAD = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW    = 3'd6;

    // Gain-stage settings handed from the top level to the back end.
    typedef struct packed {
        logic [14:0] threshold;
        logic [15:0] slope;
        logic [15:0] attack_coef;
        logic [15:0] release_coef;
        logic [15:0] makeup_gain;
    } t_gain_cfg;
endpackage
`default_nettype wire

// ===== rtl/lrc_stream_if.sv =====
// Valid/ready stream interface with a parameterized payload.
// No dependencies.
`default_nettype none
interface lrc_stream_if #(
    parameter int WIDTH = 17
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/lrc_front.sv =====
// Front end: sample ring, sliding sum of squares, fill tracking.
// Depends on lrc_pkg. Emits jobs (sum, delayed sample) into a small queue.
`default_nettype none
module lrc_front
    import lrc_pkg::*;
#(
    parameter int WINDOW_MAX    = WINDOW_MAX_D,
    parameter int LOOKAHEAD_MAX = LOOKAHEAD_MAX_D,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_D,
    parameter int SUM_BITS      = 2*SAMPLE_BITS + $clog2(WINDOW_MAX+1),
    parameter int WL_BITS       = $clog2(WINDOW_MAX+1),
    parameter int LA_BITS       = $clog2(LOOKAHEAD_MAX+1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_clear,
    input  wire logic [WL_BITS-1:0]     i_win,
    input  wire logic [LA_BITS-1:0]     i_look,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_start,
    output logic                        o_job_valid,
    output logic [SUM_BITS-1:0]         o_job_sum,
    output logic [SAMPLE_BITS-1:0]      o_job_x,
    output logic                        o_job_clr,
    input  wire logic                   i_job_full
);
    localparam int DEPTH  = WINDOW_MAX + LOOKAHEAD_MAX;
    localparam int AW     = $clog2(DEPTH);
    localparam int FW     = $clog2(DEPTH+1);
    localparam int SQ_W   = 2*SAMPLE_BITS;

    localparam logic [2:0] S_IDLE = 3'd0, S_RD_OLD = 3'd1, S_SUB = 3'd2,
                           S_RD_DLY = 3'd3, S_EMIT = 3'd4;

    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd;
    logic [2:0]             r_state, n_state;
    logic [AW-1:0]          r_wp, n_wp;
    logic [FW-1:0]          r_fill, n_fill;
    logic [SUM_BITS-1:0]    r_sum, n_sum;
    logic                   r_clr_pend, n_clr_pend;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic                   rd_en;
    logic                   wr_en;
    logic                   accept;
    logic [FW-1:0]          fill_base, lw;
    logic [AW:0]            back_off;
    logic [AW:0]            back_sum;
    logic signed [SAMPLE_BITS-1:0] sx, so;
    logic [SQ_W-1:0]        sq_new, sq_old;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign lw      = FW'(i_win) + FW'(i_look);
    assign sx      = i_sample;
    assign so      = r_rd;
    assign sq_new  = SQ_W'(sx * sx);
    assign sq_old  = SQ_W'(so * so);
    assign fill_base = i_start ? '0 : r_fill;
    assign wr_en   = accept;
    // A start request restarts the ring at entry zero with this very item.
    assign wr_addr = i_start ? '0 : r_wp;

    // Ring read address: wp - offset modulo depth.
    always_comb begin
        back_off = (r_state == S_RD_DLY) ? (AW+1)'(lw - FW'(1)) : (AW+1)'(i_win);
        if ({1'b0, r_wp} >= back_off) back_sum = {1'b0, r_wp} - back_off;
        else back_sum = {1'b0, r_wp} + (AW+1)'(DEPTH) - back_off;
        rd_addr = back_sum[AW-1:0];
        rd_en   = (r_state == S_RD_OLD) || (r_state == S_RD_DLY);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= i_sample;
        if (rd_en) r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        n_state    = r_state;
        n_wp       = r_wp;
        n_fill     = r_fill;
        n_sum      = r_sum;
        n_clr_pend = r_clr_pend;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_sum  = (i_start ? '0 : r_sum) + SUM_BITS'(sq_new);
                    n_fill = (fill_base < FW'(DEPTH)) ? fill_base + FW'(1) : fill_base;
                    if (i_start) begin
                        n_wp       = '0;
                        n_clr_pend = 1'b1;
                    end
                    n_state = S_RD_OLD;
                end
            end
            S_RD_OLD: n_state = S_SUB;
            S_SUB: begin
                if (r_fill > FW'(i_win)) n_sum = r_sum - SUM_BITS'(sq_old);
                n_state = (r_fill < lw) ? S_EMIT : S_RD_DLY;
            end
            S_RD_DLY: n_state = S_EMIT;
            S_EMIT: begin
                if (r_fill < lw) begin
                    n_wp = (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
                    n_state = S_IDLE;
                end else if (!i_job_full) begin
                    n_clr_pend = 1'b0;
                    n_wp = (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (accept && i_start) n_wp = '0;
    end

    // A start request also marks the next job so that the back end drops
    // its envelope before using it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state    <= S_IDLE;
            r_wp       <= '0;
            r_fill     <= '0;
            r_sum      <= '0;
            r_clr_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wp       <= n_wp;
            r_fill     <= n_fill;
            r_sum      <= n_sum;
            r_clr_pend <= n_clr_pend;
        end
    end

    assign o_job_valid = (r_state == S_EMIT) && (r_fill >= lw) && !i_job_full;
    assign o_job_sum   = r_sum;
    assign o_job_x     = r_rd;
    assign o_job_clr   = r_clr_pend;
endmodule
`default_nettype wire

// ===== rtl/lrc_back.sv =====
// Back end: mean division, square root, envelope, gain and output rounding.
// Depends on lrc_pkg. Pulls jobs from the queue and drives the output item.
`default_nettype none
module lrc_back
    import lrc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_D,
    parameter int SUM_BITS    = 48,
    parameter int WL_BITS     = 14
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_clear,
    input  wire t_gain_cfg              i_cfg,
    input  wire logic [WL_BITS-1:0]     i_win,
    input  wire logic                   i_job_valid,
    output logic                        o_job_take,
    input  wire logic [SUM_BITS-1:0]    i_job_sum,
    input  wire logic [SAMPLE_BITS-1:0] i_job_x,
    input  wire logic                   i_job_clr,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [SAMPLE_BITS-1:0]      o_sample,
    output logic                        o_reduced
);
    localparam int SH    = 2*(24-SAMPLE_BITS);
    localparam int NW    = SUM_BITS + SH;
    localparam int NW2   = NW + (NW % 2);
    localparam int QW    = NW2 / 2;
    localparam int CW    = $clog2(NW2 + 1);
    localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_SQRT = 3'd2,
                           S_ENV = 3'd3, S_GAIN = 3'd4, S_MUL = 3'd5, S_OUT = 3'd6;

    logic [2:0]             r_state;
    logic [CW-1:0]          r_cnt;
    logic [NW2-1:0]         r_num;    // dividend shifts out, quotient in
    logic [WL_BITS:0]       r_rem;
    logic [NW2-1:0]         r_rad;    // radicand for sqrt
    logic [QW+1:0]          r_srem;
    logic [QW-1:0]          r_root;
    logic [24:0]            r_env;
    logic                   r_jclr;
    logic [SAMPLE_BITS-1:0] r_x;
    logic signed [17:0]     r_gain;
    logic signed [SAMPLE_BITS+18:0] r_prod;
    logic                   r_red;
    logic                   r_o_red;
    logic [SAMPLE_BITS-1:0] r_osample;
    logic                   r_ovalid;

    logic [WL_BITS:0]       div_try;
    logic                   div_bit;
    logic [QW+1:0]          s_try, s_cur;
    logic [24:0]            rms;
    logic [24:0]            env_cur;
    logic [16:0]            theta;
    logic [42:0]            env_acc;
    logic [24:0]            thr;
    logic [24:0]            excess;
    logic [40:0]            red_p;
    logic [17:0]            red;
    logic signed [SAMPLE_BITS+18:0] g_x;
    logic signed [SAMPLE_BITS+36:0] p_full;
    logic signed [SAMPLE_BITS+36:0] q_v;
    logic signed [SAMPLE_BITS+36:0] smax, smin;

    assign o_job_take = (r_state == S_IDLE) && i_job_valid;
    assign div_try = {r_rem[WL_BITS-1:0], r_num[NW2-1]};
    assign div_bit = (div_try >= {1'b0, i_win});
    assign s_cur   = {r_srem[QW-1:0], r_rad[NW2-1:NW2-2]};
    assign s_try   = {r_root, 2'b01};
    assign rms     = 25'(r_root);
    // A job that follows a start request sees a cleared envelope.
    assign env_cur = r_jclr ? '0 : r_env;
    assign theta   = (rms > env_cur) ? {1'b0, i_cfg.attack_coef} : {1'b0, i_cfg.release_coef};
    assign env_acc = 43'((17'h10000 - theta) * rms) + 43'(theta * env_cur) + 43'd32768;
    assign thr     = {2'b0, i_cfg.threshold, 8'b0};
    assign excess  = r_env - thr;
    assign red_p   = 41'(excess * i_cfg.slope) + 41'(1 << 22);
    assign red     = 18'(red_p >> 23);
    assign g_x     = (SAMPLE_BITS+19)'($signed(r_x) * r_gain);
    assign p_full  = (SAMPLE_BITS+37)'(r_prod * $signed({1'b0, i_cfg.makeup_gain}))
                     + (SAMPLE_BITS+37)'(1 << 22);
    assign q_v     = p_full >>> 23;
    assign smax    = (SAMPLE_BITS+37)'((1 << (SAMPLE_BITS-1)) - 1);
    assign smin    = -smax - (SAMPLE_BITS+37)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state  <= S_IDLE;
            r_env    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && (r_state != S_OUT)) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_job_valid) begin
                    r_num   <= NW2'({i_job_sum, SH'(0)});
                    r_rem   <= '0;
                    r_x     <= i_job_x;
                    r_jclr  <= i_job_clr;
                    r_cnt   <= CW'(NW2);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // One quotient bit per cycle, restoring division.
                    if (div_bit) begin
                        r_rem <= div_try - {1'b0, i_win};
                        r_num <= {r_num[NW2-2:0], 1'b1};
                    end else begin
                        r_rem <= div_try;
                        r_num <= {r_num[NW2-2:0], 1'b0};
                    end
                    if (r_cnt == CW'(1)) begin
                        // The finished quotient becomes the radicand.
                        r_rad   <= {r_num[NW2-2:0], div_bit};
                        r_state <= S_SQRT;
                        r_cnt   <= CW'(QW);
                        r_srem  <= '0;
                        r_root  <= '0;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                S_SQRT: begin
                    // One root bit per cycle, digit-by-digit.
                    if (s_cur >= s_try) begin
                        r_srem <= s_cur - s_try;
                        r_root <= {r_root[QW-2:0], 1'b1};
                    end else begin
                        r_srem <= s_cur;
                        r_root <= {r_root[QW-2:0], 1'b0};
                    end
                    r_rad <= {r_rad[NW2-3:0], 2'b00};
                    if (r_cnt == CW'(1)) r_state <= S_ENV;
                    else r_cnt <= r_cnt - CW'(1);
                end
                S_ENV: begin
                    r_env   <= 25'(env_acc >> 16);
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_red <= r_env > thr;
                    r_gain <= (r_env > thr) ? 18'sd32768 - $signed(red) : 18'sd32768;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= g_x;
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_ovalid || i_ready) begin
                    if (q_v > smax) r_osample <= smax[SAMPLE_BITS-1:0];
                    else if (q_v < smin) r_osample <= smin[SAMPLE_BITS-1:0];
                    else r_osample <= q_v[SAMPLE_BITS-1:0];
                    r_o_red  <= r_red;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid   = r_ovalid;
    assign o_sample  = r_osample;
    assign o_reduced = r_o_red;
endmodule
`default_nettype wire

// ===== rtl/lookahead_rms_compressor.sv =====
// Top level of the lookahead RMS compressor.
// Depends on lrc_pkg, lrc_stream_if, lrc_front and lrc_back.
//
// Usage: input items {start_req, sample_in} arrive on i_in (data[15:0]
// sample, data[16] start), results {gain_reduced, sample_out} leave on o_out.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// The front end handles each item in turn: ring write, read of the sample
// leaving the window, sum update, read of the delayed sample, and a hand-off
// that waits while the job queue is full. While the ring is still filling,
// the delayed read is skipped and no job is handed off. It takes no new item
// until it is done. The back end takes a job, runs a restoring divider for the
// mean and a square root, then envelope, gain, multiply and output, and takes
// no new job until that is done. A one-entry job queue lets the front end take
// the next item while the back end works; once results flow, the back end sets the pace.
// No result appears until lookahead plus window samples are held.
// Reset clears the stream state and restores register defaults; a start
// flag or a write of either length register clears the stream state. When
// the receiver stalls, the finished item waits in the output register and
// the job queue fills, after which the input side stops accepting.
`default_nettype none
module lookahead_rms_compressor
    import lrc_pkg::*;
#(
    parameter int WINDOW_MAX    = WINDOW_MAX_D,
    parameter int LOOKAHEAD_MAX = LOOKAHEAD_MAX_D,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_D
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    lrc_stream_if.sink                    i_in,
    lrc_stream_if.source                  o_out,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);
    localparam int WL_BITS  = $clog2(WINDOW_MAX+1);
    localparam int LA_BITS  = $clog2(LOOKAHEAD_MAX+1);
    localparam int SUM_BITS = 2*SAMPLE_BITS + WL_BITS;

    t_gain_cfg     r_cfg;
    logic [7:0]    r_look;
    logic [13:0]   r_win;
    logic          cfg_clear;
    logic [WL_BITS-1:0] win_eff;
    logic [LA_BITS-1:0] look_eff;

    // A length write clears the stream state at the same edge that stores it.
    assign cfg_clear = i_cfg_we && ((i_cfg_idx == REG_LOOKAHEAD) || (i_cfg_idx == REG_WINDOW));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold    <= 15'd6554;
            r_cfg.slope        <= 16'd0;
            r_cfg.attack_coef  <= 16'd65387;
            r_cfg.release_coef <= 16'd65535;
            r_cfg.makeup_gain  <= 16'd2560;
            r_look  <= 8'd88;
            r_win   <= 14'd4410;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_THRESHOLD: r_cfg.threshold    <= i_cfg_data[14:0];
                    REG_SLOPE:     r_cfg.slope        <= i_cfg_data;
                    REG_ATTACK:    r_cfg.attack_coef  <= i_cfg_data;
                    REG_RELEASE:   r_cfg.release_coef <= i_cfg_data;
                    REG_MAKEUP:    r_cfg.makeup_gain  <= i_cfg_data;
                    REG_LOOKAHEAD: r_look <= i_cfg_data[7:0];
                    REG_WINDOW:    r_win  <= i_cfg_data[13:0];
                    default: ;
                endcase
            end
        end
    end

    // Out-of-range lengths are clamped.
    always_comb begin
        if (r_win == 14'd0) win_eff = WL_BITS'(1);
        else if (32'(r_win) > WINDOW_MAX) win_eff = WL_BITS'(WINDOW_MAX);
        else win_eff = WL_BITS'(r_win);
        if (32'(r_look) > LOOKAHEAD_MAX) look_eff = LA_BITS'(LOOKAHEAD_MAX);
        else look_eff = LA_BITS'(r_look);
    end

    // One-entry job queue between front and back.
    logic                   r_q_full;
    logic [SUM_BITS-1:0]    r_q_sum;
    logic [SAMPLE_BITS-1:0] r_q_x;
    logic                   r_q_clr;
    logic                   job_push, job_take;
    logic [SUM_BITS-1:0]    job_sum;
    logic [SAMPLE_BITS-1:0] job_x;
    logic                   job_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_clear) r_q_full <= 1'b0;
        else if (job_push) r_q_full <= 1'b1;
        else if (job_take) r_q_full <= 1'b0;
        if (job_push) begin
            r_q_sum <= job_sum;
            r_q_x   <= job_x;
            r_q_clr <= job_clr;
        end
    end

    lrc_front #(.WINDOW_MAX(WINDOW_MAX), .LOOKAHEAD_MAX(LOOKAHEAD_MAX),
                .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_clear(cfg_clear), .i_win(win_eff), .i_look(look_eff),
        .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_sample(i_in.data[SAMPLE_BITS-1:0]), .i_start(i_in.data[SAMPLE_BITS]),
        .o_job_valid(job_push), .o_job_sum(job_sum), .o_job_x(job_x),
        .o_job_clr(job_clr), .i_job_full(r_q_full)
    );

    lrc_back #(.SAMPLE_BITS(SAMPLE_BITS), .SUM_BITS(SUM_BITS), .WL_BITS(WL_BITS)) u_back (
        .i_clk, .i_rst_n, .i_clear(cfg_clear), .i_cfg(r_cfg), .i_win(win_eff),
        .i_job_valid(r_q_full), .o_job_take(job_take),
        .i_job_sum(r_q_sum), .i_job_x(r_q_x), .i_job_clr(r_q_clr),
        .o_valid(o_out.valid), .i_ready(o_out.ready),
        .o_sample(o_out.data[SAMPLE_BITS-1:0]), .o_reduced(o_out.data[SAMPLE_BITS])
    );
endmodule
`default_nettype wire

// ===== rtl/lrc_checker.sv =====
// Port-level checker for the lookahead RMS compressor, bound to the top.
// Depends on lookahead_rms_compressor_assert.svh.
`default_nettype none
`include "lookahead_rms_compressor_assert.svh"
module lrc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [16:0] out_data
);
    `LRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled item changed")
    `LRC_ASSERT_NEXT(a_ready_drops, i_clk, i_rst_n, in_valid && in_ready, !in_ready, "front took two items back to back")
    `LRC_ASSERT_IMPL(a_no_x_out, i_clk, i_rst_n, out_valid, !$isunknown(out_data), "unknown result")
endmodule
bind lookahead_rms_compressor lrc_checker u_lrc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready), .out_data(o_out.data)
);
`default_nettype wire

// ===== sim/lookahead_rms_compressor_checker.sv =====
// Checker for the lookahead RMS compressor: watches the config port and both
// channels, predicts each result and compares. Depends on lrc_pkg, lrc_stream_if.
`timescale 1ns / 1ps
module lookahead_rms_compressor_checker
    import lrc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    lrc_stream_if                    in_ch,
    lrc_stream_if                    out_ch,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_failures,
    output int                       o_pending,
    output int                       o_results,
    output int                       o_reduced
);
    localparam int RING = WINDOW_MAX_D + LOOKAHEAD_MAX_D;

    typedef struct packed {
        logic        reduced;
        logic [15:0] sample;
    } comp_out_t;

    logic [14:0] cfg_thr;
    logic [15:0] cfg_slope, cfg_att, cfg_rel, cfg_mk;
    logic [7:0]  cfg_la;
    logic [13:0] cfg_win;

    logic signed [15:0] ring_mem [RING];
    logic [63:0] sq_sum;
    logic [63:0] env_lvl;
    int          wr_ptr, fill_cnt;
    comp_out_t   comp_q [$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root, b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic int back_idx(input int off);
        return (wr_ptr + RING - off) % RING;
    endfunction

    task automatic clear_stream();
        sq_sum = 0;
        env_lvl = 0;
        wr_ptr = 0;
        fill_cnt = 0;
    endtask

    task automatic predict_sample(input logic signed [15:0] x, input logic st);
        int w, l;
        longint old, dx, g, p, q;
        logic [63:0] mean, rms, theta, thr, red;
        logic reduced;
        comp_out_t r;
        w = (cfg_win == 0) ? 1 : ((cfg_win > WINDOW_MAX_D) ? WINDOW_MAX_D : cfg_win);
        l = (cfg_la > LOOKAHEAD_MAX_D) ? LOOKAHEAD_MAX_D : cfg_la;
        if (st) clear_stream();
        ring_mem[wr_ptr] = x;
        if (fill_cnt < RING) fill_cnt++;
        sq_sum = sq_sum + 64'(longint'(x) * longint'(x));
        if (fill_cnt > w) begin
            old = ring_mem[back_idx(w)];
            sq_sum = sq_sum - 64'(old * old);
        end
        if (fill_cnt < l + w) begin
            wr_ptr = (wr_ptr + 1) % RING;
            return;
        end
        dx = ring_mem[back_idx(l + w - 1)];
        wr_ptr = (wr_ptr + 1) % RING;
        mean = (sq_sum << 16) / w;
        rms = int_sqrt(mean);
        theta = (rms > env_lvl) ? 64'(cfg_att) : 64'(cfg_rel);
        env_lvl = ((65536 - theta) * rms + theta * env_lvl + 32768) >> 16;
        thr = 64'(cfg_thr) << 8;
        reduced = env_lvl > thr;
        g = 32768;
        if (reduced) begin
            red = ((env_lvl - thr) * cfg_slope + (64'd1 << 22)) >> 23;
            g = 32768 - longint'(red);
        end
        // Arithmetic shift floors, which matches the round-half-up rule.
        p = dx * g * longint'(cfg_mk) + (64'sd1 <<< 22);
        q = p >>> 23;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        r.sample = 16'(q);
        r.reduced = reduced;
        comp_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        comp_out_t got, want;
        if (!i_rst_n) begin
            cfg_thr = 15'd6554;
            cfg_slope = 0;
            cfg_att = 16'd65387;
            cfg_rel = 16'd65535;
            cfg_mk = 16'd2560;
            cfg_la = 8'd88;
            cfg_win = 14'd4410;
            clear_stream();
            comp_q.delete();
            o_failures = 0;
            o_results = 0;
            o_reduced = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_THRESHOLD: cfg_thr = i_cfg_data[14:0];
                    REG_SLOPE:     cfg_slope = i_cfg_data;
                    REG_ATTACK:    cfg_att = i_cfg_data;
                    REG_RELEASE:   cfg_rel = i_cfg_data;
                    REG_MAKEUP:    cfg_mk = i_cfg_data;
                    REG_LOOKAHEAD: begin cfg_la = i_cfg_data[7:0]; clear_stream(); end
                    REG_WINDOW:    begin cfg_win = i_cfg_data[13:0]; clear_stream(); end
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                predict_sample(in_ch.data[15:0], in_ch.data[16]);
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                o_results++;
                if (comp_q.size() == 0) begin
                    o_failures++;
                    if (o_failures <= 10)
                        $display("%0t: unexpected result sample=%0d reduced=%0b", $realtime,
                                 $signed(got.sample), got.reduced);
                end else begin
                    want = comp_q.pop_front();
                    if (want.reduced) o_reduced++;
                    if (got !== want) begin
                        o_failures++;
                        if (o_failures <= 10)
                            $display("%0t: mismatch sample exp %0d got %0d, reduced exp %0b got %0b",
                                     $realtime, $signed(want.sample), $signed(got.sample),
                                     want.reduced, got.reduced);
                    end
                end
            end
        end
        o_pending = comp_q.size();
    end
endmodule

// ===== sim/lookahead_rms_compressor_test.sv =====
// Top of the compressor testbench: clock, reset, config phases and stimulus.
// Depends on lrc_pkg, lrc_stream_if, the block and its checker.
`timescale 1ns / 1ps
module lookahead_rms_compressor_test;
    import lrc_pkg::*;

    // An index that no register uses.
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    int failures, pending, results, reduced_cnt;
    int sent = 0;
    bit calm = 0;

    lrc_stream_if #(.WIDTH(17)) in_ch ();
    lrc_stream_if #(.WIDTH(17)) out_ch ();

    initial begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    always #5 i_clk = ~i_clk;

    lookahead_rms_compressor dut (
        .i_clk, .i_rst_n, .i_in(in_ch), .o_out(out_ch),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    lookahead_rms_compressor_checker chk (
        .i_clk, .i_rst_n, .in_ch, .out_ch, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_failures(failures), .o_pending(pending), .o_results(results),
        .o_reduced(reduced_cnt)
    );

    // Guard against a hung handshake.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // The receiver. Once a few hundred items have gone in, it holds ready low
    // for a long stretch so that the output register and the job queue fill
    // and the input side has to stall; otherwise it stalls at random unless
    // the test is in a calm stretch.
    initial begin
        int hold;
        bit held;
        hold = 0;
        held = 0;
        forever begin
            @(negedge i_clk);
            if (!held && sent >= 300) begin
                held = 1;
                hold = 600;
            end
            if (hold > 0) begin
                hold--;
                out_ch.ready = 0;
            end else begin
                out_ch.ready = calm ? 1'b1 : ($urandom_range(99) >= 18);
            end
        end
    end

    // Called at a falling edge; returns at a falling edge after the write.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = value[CFG_DATA_BITS-1:0];
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    // Registers change only when the block is idle. Items still in the front
    // end may produce no result, so after the last result we let the back end's
    // full latency pass as well.
    task automatic settle();
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    // Offers one item and returns at the falling edge after it was taken.
    // Valid stays high so back-to-back items need no extra assignment.
    task automatic send_item(input logic [15:0] smp, input logic st);
        if (!calm && $urandom_range(99) < 18) begin
            in_ch.valid = 0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        in_ch.valid = 1;
        in_ch.data = {st, smp};
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample(input bit loud);
        case ($urandom_range(loud ? 5 : 3))
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            2: return 16'($signed($urandom_range(510)) - 255);
            default: return 16'($signed($urandom_range(65535)) - 32768) | 16'h4000;
        endcase
    endfunction

    // One phase: a full register setting, then random items with the given length.
    task automatic run_phase(input int thr, input int slp, input int att, input int rel,
                             input int mk, input int la, input int win, input int n);
        settle();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_SLOPE, slp);
        write_reg(REG_ATTACK, att);
        write_reg(REG_RELEASE, rel);
        write_reg(REG_MAKEUP, mk);
        write_reg(REG_LOOKAHEAD, la);
        write_reg(REG_WINDOW, win);
        for (int i = 0; i < n; i++)
            send_item(pick_sample($urandom_range(1)), $urandom_range(199) == 0);
        in_ch.valid = 0;
    endtask

    initial begin
        int thr, win;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed part: a tiny window and lookahead, hard compression, then
        // sample extremes, a start request in mid stream and a write to an
        // index that no register uses.
        run_phase(0, 65535, 0, 65535, 65535, 2, 4, 0);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_item(16'h8000, 0);
        send_item(16'h7FFF, 0);
        send_item(16'h0000, 0);
        send_item(16'h0001, 0);
        send_item(16'hFFFF, 0);
        send_item(16'h8000, 0);
        send_item(16'h7FFF, 0);
        send_item(16'h8000, 1);
        send_item(16'h7FFF, 0);
        send_item(16'h5555, 0);
        send_item(16'hAAAA, 0);
        send_item(16'h0000, 0);
        send_item(16'h0000, 0);
        send_item(16'h0000, 0);
        in_ch.valid = 0;

        // Window length zero counts as one; lookahead zero has no delay.
        run_phase(32767, 0, 65535, 0, 0, 0, 0, 20);
        // Lengths above their maxima; too few items to leave the fill phase.
        run_phase(6554, 0, 65387, 65535, 2560, 255, 16383, 40);

        // Random phases. A calm stretch with no idling on either side.
        calm = 1;
        run_phase(8000, 40000, 30000, 65000, 256, 3, 8, 250);
        calm = 0;
        for (int p = 0; p < 6; p++) begin
            thr = $urandom_range(3) == 0 ? 32767 : $urandom_range(16000);
            win = $urandom_range(1, 32);
            run_phase(thr, $urandom_range(65535), $urandom_range(65535),
                      $urandom_range(65535), $urandom_range(1) ? 256 : $urandom_range(65535),
                      $urandom_range(48), win, 120);
        end

        // A long window with lookahead clamped to its maximum; a few dozen
        // results after the fill.
        run_phase(2000, 65535, 60000, 65535, 512, 255, 1000, 128 + 1000 + 40);

        settle();
        $display("Sent %0d items, checked %0d results, %0d with gain reduction.",
                 sent, results, reduced_cnt);
        if (failures == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
